// ----- hdl/swp_pkg.sv -----
// swp_pkg: shared types and constants for sliding_window_pool_2d.
// No dependencies.
`timescale 1ns / 1ps
package swp_pkg;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_WINDOW_H = 8;
    localparam int DEF_MAX_WINDOW_W = 8;
    localparam int MAX_HEIGHT       = 1024;
    localparam int PIX_W            = 16;
    localparam int COL_W            = 20;
    localparam int CNT_W            = 11;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_WINDOW_HEIGHT = 3'd2,
        REG_WINDOW_WIDTH  = 3'd3,
        REG_POOL_MODE     = 3'd4,
        REG_AVERAGE_SCALE = 3'd5
    } t_reg_idx;

    // Classified word passed from front to back.
    typedef struct packed {
        logic signed [COL_W-1:0] colv;   // column reduction
        logic                    col_wr; // column reduction valid for the window
        logic                    emit;   // a result is due
        logic                    last;   // last pixel of plane
        logic [3:0]              slot;   // column window slot
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] width;
        logic [CNT_W-1:0] height;
        logic [4:0]       win_h;
        logic [4:0]       win_w;
        logic             mode;
        logic [15:0]      scale;
    } t_cfg;
endpackage

// ----- hdl/swp_front.sv -----
// swp_front: position counters, line store and vertical column reduction.
// Depends on swp_pkg.
`timescale 1ns / 1ps
module swp_front #(
    parameter int MAX_WIDTH    = swp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW_H = swp_pkg::DEF_MAX_WINDOW_H,
    parameter int MAX_WINDOW_W = swp_pkg::DEF_MAX_WINDOW_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swp_pkg::t_cfg          i_cfg,
    input  logic                   i_restart,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [15:0]     i_pixel,
    output logic                   o_valid,
    input  logic                   i_ready,
    output swp_pkg::t_item         o_item
);
    import swp_pkg::*;
    localparam int LS_ROWS = (MAX_WINDOW_H > 1) ? MAX_WINDOW_H - 1 : 1;
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int RW      = (LS_ROWS > 1) ? $clog2(LS_ROWS) : 1;
    localparam int WW      = (MAX_WINDOW_W > 1) ? $clog2(MAX_WINDOW_W) : 1;

    // Stage A: counters and line store read. Stage B: column reduction.
    logic [CNT_W-1:0] r_row, r_col, n_row, n_col;
    logic [RW-1:0]    r_wrow, n_wrow;   // line-store row written this line
    logic             r_a_vld;
    logic signed [15:0] r_a_pix;
    logic [CNT_W-1:0] r_a_row, r_a_col;
    logic [RW-1:0]    r_a_wrow;
    logic             r_a_last;
    logic signed [15:0] r_ls_q [LS_ROWS];
    logic             r_b_vld;
    t_item            r_b_item;

    logic adv_b, adv_a;
    assign adv_b   = !r_b_vld || i_ready;
    assign adv_a   = !r_a_vld || adv_b;
    assign o_ready = adv_a;
    assign o_valid = r_b_vld;
    assign o_item  = r_b_item;

    logic acc_in;
    assign acc_in = i_valid && adv_a;

    logic [XW-1:0] col_idx;
    always_comb begin
        col_idx = (int'(r_col) >= MAX_WIDTH) ? XW'(MAX_WIDTH - 1) : XW'(r_col);
        n_row  = r_row;
        n_col  = r_col;
        n_wrow = r_wrow;
        if (acc_in) begin
            if (r_col + 1'b1 >= i_cfg.width) begin
                n_col  = '0;
                n_wrow = (32'(r_wrow) + 1 >= LS_ROWS) ? '0 : RW'(r_wrow + 1'b1);
                if (r_row + 1'b1 >= i_cfg.height) n_row = '0;
                else n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_wrow <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_wrow <= n_wrow;
        end
    end

    // One memory per stored row; read all rows and write the current row at a column.
    genvar g;
    generate
        for (g = 0; g < LS_ROWS; g++) begin : g_ls
            logic signed [15:0] mem [MAX_WIDTH];
            always_ff @(posedge i_clk) begin
                if (acc_in) begin
                    r_ls_q[g] <= mem[col_idx];
                    if (i_cfg.win_h > 5'd1 && r_wrow == RW'(g)) mem[col_idx] <= i_pixel;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else if (adv_a) r_a_vld <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_a_pix  <= i_pixel;
            r_a_row  <= r_row;
            r_a_col  <= r_col;
            r_a_wrow <= r_wrow;
            r_a_last <= (r_row + 1'b1 >= i_cfg.height) && (r_col + 1'b1 >= i_cfg.width);
        end
    end

    // Column reduction over the rows above (row r-k lives k rows back in the ring).
    t_item n_item;
    always_comb begin
        logic fits;
        logic signed [COL_W-1:0] acc, v;
        int idx;
        fits = (CNT_W'(i_cfg.win_h) <= i_cfg.height) && (CNT_W'(i_cfg.win_w) <= i_cfg.width);
        acc  = COL_W'(r_a_pix);
        for (int k = 1; k < MAX_WINDOW_H; k++) begin
            idx = int'(r_a_wrow) - k;
            if (idx < 0) idx = idx + LS_ROWS;
            v = COL_W'(r_ls_q[idx[RW-1:0]]);
            if (k < int'(i_cfg.win_h)) begin
                if (i_cfg.mode) acc = acc + v;
                else if (v > acc) acc = v;
            end
        end
        n_item.colv   = acc;
        n_item.col_wr = fits && (r_a_row + 1'b1 >= CNT_W'(i_cfg.win_h));
        n_item.emit   = n_item.col_wr && (r_a_col + 1'b1 >= CNT_W'(i_cfg.win_w));
        n_item.last   = r_a_last;
        n_item.slot   = 4'(r_a_col[WW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else if (adv_b) r_b_vld <= r_a_vld;
    end
    always_ff @(posedge i_clk) begin
        if (adv_b && r_a_vld) r_b_item <= n_item;
    end
endmodule

// ----- hdl/swp_fifo.sv -----
// swp_fifo: short queue decoupling front and back.
// Depends on swp_pkg.
`timescale 1ns / 1ps
module swp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  swp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output swp_pkg::t_item o_item
);
    import swp_pkg::*;
    t_item      r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic wr, rd;
    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_item  = r_q[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= i_item;
    end
`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd4 |=> r_cnt != 3'd0) else $error("queue count jumped");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0 || r_cnt == 3'd4) |-> r_wp == r_rp) else $error("pointer mismatch");
`endif
endmodule

// ----- hdl/swp_back.sv -----
// swp_back: column window, horizontal reduction, scaling and output register.
// Depends on swp_pkg.
`timescale 1ns / 1ps
module swp_back #(
    parameter int MAX_WINDOW_W = swp_pkg::DEF_MAX_WINDOW_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swp_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  swp_pkg::t_item     i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_pooled,
    output logic               o_last
);
    import swp_pkg::*;
    localparam int WW = (MAX_WINDOW_W > 1) ? $clog2(MAX_WINDOW_W) : 1;
    localparam int SW = COL_W + 4;

    logic signed [COL_W-1:0] r_cw [MAX_WINDOW_W];
    // Stage 1: reduction. Stage 2: multiply. Stage 3: round/saturate (average) or pass max to output.
    logic r_s1_vld, r_s2_vld, r_o_vld;
    logic signed [SW-1:0] r_s1_acc;
    logic r_s1_mode, r_s1_last, r_s2_mode, r_s2_last;
    logic signed [SW+17-1:0] r_s2_prod;
    logic signed [15:0] r_s2_max;
    logic signed [15:0] r_out;
    logic r_o_last;

    logic adv_o, adv_2, adv_1;
    assign adv_o   = !r_o_vld || i_ready;
    assign adv_2   = !r_s2_vld || adv_o;
    assign adv_1   = !r_s1_vld || adv_2;
    assign o_ready = adv_1;
    logic take;
    assign take = i_valid && adv_1;

    logic signed [SW-1:0] n_acc;
    logic signed [15:0]   n_sat;
    always_comb begin
        logic signed [SW-1:0] v;
        int idx;
        n_acc = SW'(i_item.colv);
        for (int k = 1; k < MAX_WINDOW_W; k++) begin
            idx = int'(i_item.slot[WW-1:0]) - k;
            if (idx < 0) idx = idx + MAX_WINDOW_W;
            v = SW'(r_cw[idx[WW-1:0]]);
            if (k < int'(i_cfg.win_w)) begin
                if (i_cfg.mode) n_acc = n_acc + v;
                else if (v > n_acc) n_acc = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_item.col_wr) r_cw[i_item.slot[WW-1:0]] <= i_item.colv;
        if (take) begin
            r_s1_acc  <= n_acc;
            r_s1_mode <= i_cfg.mode;
            r_s1_last <= i_item.last;
        end
        if (adv_2 && r_s1_vld) begin
            r_s2_prod <= (SW+17)'(r_s1_acc) * $signed({1'b0, i_cfg.scale});
            r_s2_max  <= r_s1_acc[15:0];
            r_s2_mode <= r_s1_mode;
            r_s2_last <= r_s1_last;
        end
        if (adv_o && r_s2_vld) begin
            r_o_last <= r_s2_last;
            if (r_s2_mode) r_out <= n_sat;
            else r_out <= r_s2_max;
        end
    end

    always_comb begin
        logic signed [SW+17-1:0] q;
        q = (r_s2_prod + (SW+17)'(32768)) >>> 16;
        if (q > (SW+17)'(32767)) n_sat = 16'sh7fff;
        else if (q < -(SW+17)'(32768)) n_sat = -16'sh8000;
        else n_sat = q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0; r_s2_vld <= 1'b0; r_o_vld <= 1'b0;
        end else begin
            if (adv_1) r_s1_vld <= i_valid && i_item.emit;
            if (adv_2) r_s2_vld <= r_s1_vld;
            if (adv_o) r_o_vld <= r_s2_vld;
        end
    end
    assign o_valid  = r_o_vld;
    assign o_pooled = r_out;
    assign o_last   = r_o_last;
`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && !i_ready |=> r_o_vld && $stable(r_out)) else $error("output dropped");
    a_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && !adv_o |=> r_s2_vld) else $error("stage lost");
    a_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !adv_2 |=> r_s1_vld) else $error("stage lost");
`endif
endmodule

// ----- hdl/sliding_window_pool_2d.sv -----
// sliding_window_pool_2d: stride-1 max/average pooling, top level.
// Throughput one pixel word per cycle while m_axis_tready does not stall the output.
// Rate is set by the single-port line store read and the combinational window reduction.
// Reset (synchronous, active low) clears counters, handshake state and configuration registers to
// their reset values; line store and column window are left as they are.
// Depends on swp_pkg, swp_front, swp_fifo, swp_back.
`timescale 1ns / 1ps
module sliding_window_pool_2d #(
    parameter int MAX_WIDTH    = swp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW_H = swp_pkg::DEF_MAX_WINDOW_H,
    parameter int MAX_WINDOW_W = swp_pkg::DEF_MAX_WINDOW_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pooled
    output logic        m_axis_tlast,   // plane_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swp_pkg::*;

    t_cfg r_cfg;
    logic wr;
    t_reg_idx ridx;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign ridx = t_reg_idx'(paddr[4:2]);

    function automatic logic [CNT_W-1:0] clamp11(logic [10:0] v, int hi);
        if (v == '0) return CNT_W'(1);
        if (int'(v) > hi) return CNT_W'(hi);
        return v;
    endfunction
    function automatic logic [4:0] clamp4(logic [3:0] v, int hi);
        if (v == '0) return 5'd1;
        if (int'(v) > hi) return 5'(hi);
        return {1'b0, v};
    endfunction

    logic restart;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= CNT_W'(1);
            r_cfg.height <= CNT_W'(1);
            r_cfg.win_h  <= clamp4(4'd2, MAX_WINDOW_H);
            r_cfg.win_w  <= clamp4(4'd2, MAX_WINDOW_W);
            r_cfg.mode   <= 1'b0;
            r_cfg.scale  <= 16'd16384;
        end else if (wr) begin
            case (ridx)
                REG_IMAGE_WIDTH:   r_cfg.width  <= clamp11(pwdata[10:0], MAX_WIDTH);
                REG_IMAGE_HEIGHT:  r_cfg.height <= clamp11(pwdata[10:0], MAX_HEIGHT);
                REG_WINDOW_HEIGHT: r_cfg.win_h  <= clamp4(pwdata[3:0], MAX_WINDOW_H);
                REG_WINDOW_WIDTH:  r_cfg.win_w  <= clamp4(pwdata[3:0], MAX_WINDOW_W);
                REG_POOL_MODE:     r_cfg.mode   <= pwdata[0];
                REG_AVERAGE_SCALE: r_cfg.scale  <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    // Any write to a defined register restarts the plane.
    assign restart = wr && (paddr[4:2] <= 3'd5);

    always_comb begin
        prdata = '0;
        case (ridx)
            REG_IMAGE_WIDTH:   prdata = 32'(r_cfg.width);
            REG_IMAGE_HEIGHT:  prdata = 32'(r_cfg.height);
            REG_WINDOW_HEIGHT: prdata = 32'(r_cfg.win_h);
            REG_WINDOW_WIDTH:  prdata = 32'(r_cfg.win_w);
            REG_POOL_MODE:     prdata = 32'(r_cfg.mode);
            REG_AVERAGE_SCALE: prdata = 32'(r_cfg.scale);
            default:           prdata = '0;
        endcase
    end

    logic  f_vld, f_rdy, q_vld, q_rdy;
    t_item f_item, q_item;

    swp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW_H(MAX_WINDOW_H),
                .MAX_WINDOW_W(MAX_WINDOW_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_restart(restart),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_pixel(s_axis_tdata),
        .o_valid(f_vld), .i_ready(f_rdy), .o_item(f_item)
    );

    swp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_vld), .o_ready(f_rdy),
        .i_item(f_item), .o_valid(q_vld), .i_ready(q_rdy), .o_item(q_item)
    );

    logic signed [15:0] pooled;
    swp_back #(.MAX_WINDOW_W(MAX_WINDOW_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(q_vld), .o_ready(q_rdy), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_pooled(pooled), .o_last(m_axis_tlast)
    );
    assign m_axis_tdata = pooled;
`ifndef SYNTHESIS
    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");
    a_cfg_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.width != '0 && r_cfg.height != '0) else $error("zero size");
    a_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.win_h != '0 && r_cfg.win_w != '0) else $error("zero window");
`endif
endmodule

// ----- tb/sliding_window_pool_2d_tb.sv -----
// sliding_window_pool_2d_tb: self-checking bench for the stride-1 pooling block.
// Pooled words are predicted by an in-bench window model and checked in order.
// Depends on swp_pkg and sliding_window_pool_2d.
`timescale 1ns / 1ps
module sliding_window_pool_2d_tb;
    import swp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LS_ROWS      = 7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;       // [15:0] pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] pooled
    logic        m_axis_tlast;            // plane_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sliding_window_pool_2d DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct {
        logic signed [15:0] pooled;
        logic               plane_end;
    } t_pool_word;

    logic [15:0] pixel_q[$];      // pixels waiting for the driver
    t_pool_word  pooled_q[$];     // predicted results in order

    int sender_idle_pct = 19;
    int receiver_idle_pct = 48;
    int error_count = 0;
    int pixels_in = 0;
    int results_seen = 0;
    int phase_count = 0;
    int cycle_count = 0;

    // Mirror of the block's configuration (clamped) and window state.
    int cfg_width = 1, cfg_height = 1, cfg_win_h = 2, cfg_win_w = 2;
    bit cfg_mode = 1'b0;
    int cfg_scale = 16384;
    logic signed [15:0] line_rows [LS_ROWS][1024];
    int col_red [8];
    int cur_row = 0, cur_col = 0;

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Window sum times the Q0.16 scale, round half up, saturate to signed Q16.0.
    function automatic int scaled_mean(longint sum);
        longint q;
        q = (sum * longint'(cfg_scale) + 64'sd32768) >>> 16;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    // Advance the window model by one pixel; returns 1 when a result is due.
    function automatic bit pool_pixel(logic signed [15:0] px, output t_pool_word res);
        int  r, c, k, colv;
        longint acc;
        bit  fits, last, got;
        r = cur_row;
        c = cur_col;
        got = 1'b0;
        fits = cfg_win_h <= cfg_height && cfg_win_w <= cfg_width;
        last = (r + 1 >= cfg_height) && (c + 1 >= cfg_width);
        if (fits && r + 1 >= cfg_win_h) begin
            colv = px;
            for (k = 1; k < cfg_win_h; k++) begin
                if (cfg_mode) colv += line_rows[(r - k) % LS_ROWS][c];
                else if (line_rows[(r - k) % LS_ROWS][c] > colv)
                    colv = line_rows[(r - k) % LS_ROWS][c];
            end
            col_red[c % 8] = colv;
            if (c + 1 >= cfg_win_w) begin
                acc = col_red[c % 8];
                for (k = 1; k < cfg_win_w; k++) begin
                    if (cfg_mode) acc += col_red[(c - k) % 8];
                    else if (col_red[(c - k) % 8] > acc) acc = col_red[(c - k) % 8];
                end
                res.pooled = cfg_mode ? 16'(scaled_mean(acc)) : 16'(acc);
                res.plane_end = last;
                got = 1'b1;
            end
        end
        if (cfg_win_h > 1) line_rows[r % LS_ROWS][c] = px;
        if (c + 1 >= cfg_width) begin
            cur_col = 0;
            cur_row = (r + 1 >= cfg_height) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
        return got;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR word %0d: %s got %0d want %0d", results_seen, what, got, want);
        error_count++;
    endtask

    // Driver: hold the word until accepted, then maybe idle.
    always @(posedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_axis_tready)) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if (i_rst_n) m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: predict on input accept, check on output accept.
    always @(posedge i_clk) begin
        t_pool_word exp_w, res;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pixels_in++;
                if (pool_pixel(s_axis_tdata, res)) pooled_q.push_back(res);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pooled_q.size() == 0) begin
                    report_mismatch("unexpected word, pooled", int'($signed(m_axis_tdata)), 0);
                end else begin
                    exp_w = pooled_q.pop_front();
                    if (m_axis_tdata !== exp_w.pooled)
                        report_mismatch("pooled", int'($signed(m_axis_tdata)),
                                        int'(exp_w.pooled));
                    if (m_axis_tlast !== exp_w.plane_end)
                        report_mismatch("plane_end", int'(m_axis_tlast),
                                        int'(exp_w.plane_end));
                end
                results_seen++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // APB write: setup then access; mirror the clamp and the counter restart.
    task automatic write_reg(t_reg_idx idx, int value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = clamp_int(value & 'h7FF, 1, 1024);
            REG_IMAGE_HEIGHT:  cfg_height = clamp_int(value & 'h7FF, 1, 1024);
            REG_WINDOW_HEIGHT: cfg_win_h  = clamp_int(value & 'hF, 1, 8);
            REG_WINDOW_WIDTH:  cfg_win_w  = clamp_int(value & 'hF, 1, 8);
            REG_POOL_MODE:     cfg_mode   = value[0];
            REG_AVERAGE_SCALE: cfg_scale  = value & 'hFFFF;
            default: ;
        endcase
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic configure(int w, int h, int wh, int ww, int mode, int scale);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_WINDOW_HEIGHT, wh);
        write_reg(REG_WINDOW_WIDTH, ww);
        write_reg(REG_POOL_MODE, mode);
        write_reg(REG_AVERAGE_SCALE, scale);
        phase_count++;
    endtask

    // Block idle: nothing queued, nothing in flight, then let the pipe drain.
    // Checked at the falling edge so driver and monitor updates have settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pixel_q.size() > 0 || s_axis_tvalid || pooled_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int w, h, wh, ww, n, mode, scale;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setup: 1x1 image with a 2x2 window yields nothing.
        repeat (3) pixel_q.push_back(rand_pixel());
        wait_idle();

        // 3x3 max with the field extremes.
        configure(3, 3, 2, 2, 0, 16384);
        pixel_q.push_back(16'h8000); pixel_q.push_back(16'h7FFF);
        pixel_q.push_back(16'h0000); pixel_q.push_back(16'h8000);
        pixel_q.push_back(16'h8000); pixel_q.push_back(16'hFFFF);
        pixel_q.push_back(16'h0001); pixel_q.push_back(16'h7FFF);
        pixel_q.push_back(16'h8000);
        wait_idle();

        // Average saturation both ways, largest scale, 1x2 window.
        configure(2, 2, 1, 2, 1, 65535);
        pixel_q.push_back(16'h7FFF); pixel_q.push_back(16'h7FFF);
        pixel_q.push_back(16'h8000); pixel_q.push_back(16'h8000);
        wait_idle();

        // Out-of-range registers clamp: width 0 -> 1, height 2047 -> 1024,
        // window 15x0 -> 8x1, zero scale.
        configure(0, 2047, 15, 0, 1, 0);
        repeat (4) pixel_q.push_back(rand_pixel());
        wait_idle();

        // Widest image with a 1x8 window, partial plane.
        configure(1024, 2, 1, 8, 0, 8192);
        repeat (4) pixel_q.push_back(rand_pixel());
        wait_idle();

        while (pixels_in < 1150) begin
            if (pixels_in > 760) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end else if (pixels_in > 380) begin
                sender_idle_pct = 48;
                receiver_idle_pct = 19;
            end
            w  = ($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(1, 12);
            h  = ($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(1, 10);
            wh = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
            ww = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
            mode = $urandom_range(1);
            scale = ($urandom_range(3) == 0) ? $urandom_range(65535)
                  : 65536 / (clamp_int(wh & 'hF, 1, 8) * clamp_int(ww & 'hF, 1, 8));
            if (scale > 65535) scale = 65535;
            configure(w, h, wh, ww, mode, scale);
            n = clamp_int(cfg_width * cfg_height * $urandom_range(1, 3), 1, 80);
            repeat (n) pixel_q.push_back(rand_pixel());
            wait_idle();
        end

        $display("%0d pixel words in %0d register setups, %0d pooled words checked",
                 pixels_in, phase_count, results_seen);
        $display("max and average modes, clamped sizes, saturation, oversized windows");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", error_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/swp_pkg.sv
hdl/swp_front.sv
hdl/swp_fifo.sv
hdl/swp_back.sv
hdl/sliding_window_pool_2d.sv
tb/sliding_window_pool_2d_tb.sv
